// ===== sv/round_robin_task_scheduler_fast_queue_core_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_FAST_QUEUE_CORE_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_FAST_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RRS_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define RRS_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/rrtsfq_pkg.sv =====
package rrtsfq_pkg;

    localparam int ID_W    = 4;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 16;
    localparam int COUNT_W = 5;

    // Transaction kinds
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_SLEEP  = 2'd1;
    localparam logic [1:0] KIND_WAKE   = 2'd2;
    localparam logic [1:0] KIND_SWITCH = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] sleep_interval;
        logic [TIME_W-1:0] now;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]  next_task;
        logic             switched;
        logic             by_fast_serve;
        logic             none_ready;
        logic [CNT_W-1:0] idle_count;
        logic [CNT_W-1:0] leaving_heartbeat;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic push;
        logic wake;
        logic sleep_wr;
        logic beat_wr;
        logic fast_pop;
        logic scan_init;
        logic scan_eval;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] kind;
        logic       fifo_nonempty;
        logic       scan_ready;
        logic       scan_last;
    } ctrl_status_t;

endpackage

// ===== sv/rrtsfq_ctrl.sv =====
module rrtsfq_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  logic                     out_stall,
    output rrtsfq_pkg::ctrl_cmd_t    cmd,
    input  rrtsfq_pkg::ctrl_status_t status
);
    import rrtsfq_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_OP      = 3'd1;
    localparam logic [2:0] S_BEAT    = 3'd2;
    localparam logic [2:0] S_SCAN_RD = 3'd3;
    localparam logic [2:0] S_SCAN_EV = 3'd4;
    localparam logic [2:0] S_FIN     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Sequence one transaction through the datapath
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg & out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_OP;
                end
            end
            S_OP:
            begin
                case (status.kind)
                    KIND_PUSH:
                    begin
                        cmd.push   = 1'b1;
                        state_next = S_FIN;
                    end
                    KIND_WAKE:
                    begin
                        cmd.wake   = 1'b1;
                        state_next = S_FIN;
                    end
                    KIND_SLEEP:
                    begin
                        cmd.sleep_wr = 1'b1;
                        state_next   = S_BEAT;
                    end
                    default:
                    begin
                        state_next = S_BEAT;
                    end
                endcase
            end
            S_BEAT:
            begin
                cmd.beat_wr = 1'b1;
                if (status.fifo_nonempty)
                begin
                    cmd.fast_pop = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
                if (status.scan_ready || status.scan_last)
                    state_next = S_FIN;
                else
                    state_next = S_SCAN_RD;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/rrtsfq_datapath.sv =====
module rrtsfq_datapath #(
    parameter int MAX_TASKS  = 16,
    parameter int FIFO_DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [rrtsfq_pkg::COUNT_W-1:0]          cfg_wr_data,
    input  rrtsfq_pkg::in_item_t                    in_data,
    output rrtsfq_pkg::out_item_t                   out_data,
    input  rrtsfq_pkg::ctrl_cmd_t                   cmd,
    output rrtsfq_pkg::ctrl_status_t                status
);
    import rrtsfq_pkg::*;

    localparam int TW = $clog2(MAX_TASKS);
    localparam int NW = $clog2(MAX_TASKS + 1);
    localparam int FW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    // Next task around a ring of n tasks; anything past the end goes to task 0
    function automatic logic [TW-1:0] succ(input logic [TW-1:0] t, input logic [NW-1:0] n);
        logic [NW:0] t1;
        t1 = (NW+1)'(t) + (NW+1)'(1);
        succ = (t1 >= (NW+1)'(n)) ? '0 : TW'(t1);
    endfunction

    function automatic logic [FW-1:0] ptr_inc(input logic [FW-1:0] p);
        ptr_inc = (p == FW'(FIFO_DEPTH - 1)) ? '0 : p + FW'(1);
    endfunction

    // Storage
    logic [TIME_W-1:0] interval_mem [MAX_TASKS];
    logic [TIME_W-1:0] mark_mem     [MAX_TASKS];
    logic [CNT_W-1:0]  beat_mem     [MAX_TASKS];
    logic [ID_W-1:0]   fifo_mem     [FIFO_DEPTH];

    logic [TIME_W-1:0] intv_q;
    logic [TIME_W-1:0] mark_q;
    logic              iv_q;
    logic [CNT_W-1:0]  beat_q;
    logic              bv_q;
    logic [ID_W-1:0]   fifo_q;

    in_item_t          item_reg;
    out_item_t         out_reg;
    out_item_t         out_next;

    logic [COUNT_W-1:0] task_count_reg, task_count_next;
    logic [TW-1:0]      cur_reg, cur_next;
    logic [TW-1:0]      saved_reg, saved_next;
    logic               saved_valid_reg, saved_valid_next;
    logic [FW-1:0]      wp_reg, wp_next;
    logic [FW-1:0]      rp_reg, rp_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [CNT_W-1:0]   idle_reg, idle_next;
    logic [MAX_TASKS-1:0] ival_reg, ival_next;
    logic [MAX_TASKS-1:0] bval_reg, bval_next;
    logic [TW-1:0]      p_reg, p_next;
    logic [TW-1:0]      k_reg, k_next;
    logic               sw_reg, sw_next;
    logic               fast_reg, fast_next;
    logic               none_reg, none_next;
    logic [CNT_W-1:0]   beat_reg, beat_next;

    logic [NW-1:0]      ring_n;
    logic               id_ok;
    logic [TW-1:0]      id_t;
    logic [TW-1:0]      fast_t;
    logic [TW-1:0]      succ_cur;
    logic [CNT_W-1:0]   beat_inc;
    logic [TIME_W-1:0]  elapsed;
    logic               scan_ready;
    logic               scan_last;

    // Clamp the configured ring size to 1..MAX_TASKS
    always_comb
    begin
        if (task_count_reg == '0)
            ring_n = NW'(1);
        else if (int'(task_count_reg) > MAX_TASKS)
            ring_n = NW'(MAX_TASKS);
        else
            ring_n = NW'(task_count_reg);
    end

    assign id_ok    = (int'(item_reg.task_id) < MAX_TASKS);
    assign id_t     = TW'(item_reg.task_id);
    assign fast_t   = TW'(fifo_q);
    assign succ_cur = succ(cur_reg, ring_n);
    assign beat_inc = (bv_q ? beat_q : '0) + CNT_W'(1);

    // Readiness of the scanned task under wrapping time
    assign elapsed    = item_reg.now - mark_q;
    assign scan_ready = !iv_q || (intv_q == '0) || (elapsed >= intv_q);
    assign scan_last  = ((NW+1)'(k_reg) + (NW+1)'(1)) == (NW+1)'(ring_n);

    assign status.kind          = item_reg.kind;
    assign status.fifo_nonempty = (fill_reg != '0);
    assign status.scan_ready    = scan_ready;
    assign status.scan_last     = scan_last;

    assign out_data = out_reg;

    // Per-task tables: write on command, read every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.sleep_wr)
        begin
            interval_mem[cur_reg] <= item_reg.sleep_interval;
            mark_mem[cur_reg]     <= item_reg.now;
        end
        intv_q <= interval_mem[p_reg];
        mark_q <= mark_mem[p_reg];
        iv_q   <= ival_reg[p_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.beat_wr)
            beat_mem[cur_reg] <= beat_inc;
        beat_q <= beat_mem[cur_reg];
        bv_q   <= bval_reg[cur_reg];
    end

    // Fast-serve queue storage
    always_ff @(posedge clk)
    begin
        if (cmd.push && id_ok)
            fifo_mem[wp_reg] <= item_reg.task_id;
        fifo_q <= fifo_mem[rp_reg];
    end

    // Hold the accepted item and the finished result
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_data;
        if (cmd.finish)
            out_reg <= out_next;
    end

    always_comb
    begin
        out_next.next_task         = ID_W'(cur_reg);
        out_next.switched          = sw_reg;
        out_next.by_fast_serve     = fast_reg;
        out_next.none_ready        = none_reg;
        out_next.idle_count        = idle_reg;
        out_next.leaving_heartbeat = beat_reg;
    end

    // Scheduler state updates
    always_comb
    begin
        task_count_next  = task_count_reg;
        cur_next         = cur_reg;
        saved_next       = saved_reg;
        saved_valid_next = saved_valid_reg;
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        fill_next        = fill_reg;
        idle_next        = idle_reg;
        ival_next        = ival_reg;
        bval_next        = bval_reg;
        p_next           = p_reg;
        k_next           = k_reg;
        sw_next          = sw_reg;
        fast_next        = fast_reg;
        none_next        = none_reg;
        beat_next        = beat_reg;

        if (cfg_wr_en)
            task_count_next = cfg_wr_data;

        if (cmd.load_item)
        begin
            sw_next   = 1'b0;
            fast_next = 1'b0;
            none_next = 1'b0;
            beat_next = '0;
        end

        // Push; a full queue drops its oldest entry
        if (cmd.push && id_ok)
        begin
            wp_next = ptr_inc(wp_reg);
            if (fill_reg < CW'(FIFO_DEPTH))
                fill_next = fill_reg + CW'(1);
            if (fill_next == CW'(FIFO_DEPTH))
                rp_next = wp_next;
        end

        if (cmd.wake && id_ok)
            ival_next[id_t] = 1'b0;

        if (cmd.sleep_wr)
            ival_next[cur_reg] = 1'b1;

        // Bump the leaving task's heartbeat
        if (cmd.beat_wr)
        begin
            bval_next[cur_reg] = 1'b1;
            beat_next          = beat_inc;
            sw_next            = 1'b1;
        end

        // Serve the queue head and remember the ring position
        if (cmd.fast_pop)
        begin
            rp_next   = ptr_inc(rp_reg);
            fill_next = fill_reg - CW'(1);
            if (!saved_valid_reg)
            begin
                saved_next       = (succ_cur == fast_t) ? succ(succ_cur, ring_n) : succ_cur;
                saved_valid_next = 1'b1;
            end
            else if (saved_reg == fast_t)
            begin
                saved_next = succ(saved_reg, ring_n);
            end
            fast_next         = 1'b1;
            cur_next          = fast_t;
            ival_next[fast_t] = 1'b0;
        end

        // Start the ring scan at the restored or following position
        if (cmd.scan_init)
        begin
            if (saved_valid_reg)
                p_next = (NW'(saved_reg) < ring_n) ? saved_reg : '0;
            else
                p_next = succ_cur;
            saved_valid_next = 1'b0;
            k_next           = '0;
        end

        // Take the scanned task or skip it as idle
        if (cmd.scan_eval)
        begin
            if (scan_ready)
            begin
                cur_next        = p_reg;
                ival_next[p_reg] = 1'b0;
            end
            else
            begin
                idle_next = idle_reg + CNT_W'(1);
                p_next    = succ(p_reg, ring_n);
                k_next    = k_reg + TW'(1);
                if (scan_last)
                    none_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg  <= COUNT_W'(1);
            cur_reg         <= '0;
            saved_reg       <= '0;
            saved_valid_reg <= 1'b0;
            wp_reg          <= '0;
            rp_reg          <= '0;
            fill_reg        <= '0;
            idle_reg        <= '0;
            ival_reg        <= '0;
            bval_reg        <= '0;
            p_reg           <= '0;
            k_reg           <= '0;
            sw_reg          <= 1'b0;
            fast_reg        <= 1'b0;
            none_reg        <= 1'b0;
            beat_reg        <= '0;
        end
        else
        begin
            task_count_reg  <= task_count_next;
            cur_reg         <= cur_next;
            saved_reg       <= saved_next;
            saved_valid_reg <= saved_valid_next;
            wp_reg          <= wp_next;
            rp_reg          <= rp_next;
            fill_reg        <= fill_next;
            idle_reg        <= idle_next;
            ival_reg        <= ival_next;
            bval_reg        <= bval_next;
            p_reg           <= p_next;
            k_reg           <= k_next;
            sw_reg          <= sw_next;
            fast_reg        <= fast_next;
            none_reg        <= none_next;
            beat_reg        <= beat_next;
        end
    end

endmodule

// ===== sv/round_robin_task_scheduler_fast_queue_core.sv =====
// Round-robin task scheduler with a fast-serve queue. One transaction is in
// flight at a time: after acceptance, a push or a wake passes S_OP and S_FIN,
// a switch served from the queue S_OP, S_BEAT and S_FIN, and a ring scan adds
// S_SCAN_RD and S_SCAN_EV for each of m tasks looked at (1 up to the ring
// size, which is task_count held to 1..MAX_TASKS). The scan is bounded by the
// per-task interval and timestamp memories, which give one registered read
// per task and are evaluated in the following cycle. The result sits in an
// output register, and the next transaction is accepted while that result
// waits to be taken. No clearing pass follows reset; per-task valid bits
// stand for the zeroed tables. The user must write task_count (cfg_wr_en/
// cfg_wr_data) only while idle; the block itself does not enforce it.
module round_robin_task_scheduler_fast_queue_core #(
    parameter int MAX_TASKS  = 16,
    parameter int FIFO_DEPTH = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rrtsfq_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  rrtsfq_pkg::in_item_t           in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output rrtsfq_pkg::out_item_t          out_data
);
    import rrtsfq_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    rrtsfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    rrtsfq_datapath #(
        .MAX_TASKS  (MAX_TASKS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .out_data    (out_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== sv/rrtsfq_checker.sv =====
`include "round_robin_task_scheduler_fast_queue_core_macros.svh"

module rrtsfq_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input rrtsfq_pkg::out_item_t out_data
);
    import rrtsfq_pkg::*;

    // A held result stays put
    `RRS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // Only one transaction in flight
    `RRS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

    // No decision means no decision flags and no heartbeat
    `RRS_ASSERT_IMP(a_no_switch_flags, clk, rst_n, out_valid && !out_data.switched, !out_data.by_fast_serve && !out_data.none_ready && (out_data.leaving_heartbeat == '0))

    // A queue hit never reports an empty ring
    `RRS_ASSERT_IMP(a_fast_not_none, clk, rst_n, out_valid && out_data.by_fast_serve, !out_data.none_ready)

endmodule

bind round_robin_task_scheduler_fast_queue_core rrtsfq_checker u_checker (.*);
